[rtl/turing_machine_step_engine_assert.svh]
// assertion macros for the step engine top level
`ifndef TURING_MACHINE_STEP_ENGINE_ASSERT_SVH
`define TURING_MACHINE_STEP_ENGINE_ASSERT_SVH

// condition must never hold outside reset
`define TMSE_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

// antecedent in one cycle implies consequent in the next
`define TMSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tmse_pkg.sv]
// shared types and constants of the turing machine step engine
package tmse_pkg;

  localparam int STATE_COUNT_DEF = 16;
  localparam int TAPE_CELLS_DEF  = 1024;

  localparam int SYM_W   = 8;
  localparam int STATE_W = 4;
  localparam int POS_W   = 10;
  localparam int CMD_W   = 2;
  localparam int MOVE_W  = 2;
  localparam int STAT_W  = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // blank symbol after reset: '.'
  localparam logic [SYM_W-1:0] BLANK_RESET = 8'h2E;

  // head moves ('L' and 'R'); the other codes mean no move
  localparam logic [MOVE_W-1:0] MOVE_LEFT  = 2'd1;
  localparam logic [MOVE_W-1:0] MOVE_RIGHT = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLANK_SYMBOL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_STATE  = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_RULE = 2'd0,
    CMD_WRITE_CELL = 2'd1,
    CMD_RESTART    = 2'd2,
    CMD_STEP       = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_ACCEPTED  = 2'd0,
    STAT_STEPPED   = 2'd1,
    STAT_HALTED    = 2'd2,
    STAT_EDGE_HELD = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RULE_RD,
    S_COMMIT,
    S_FINISH
  } seq_state_t;

  typedef struct packed {
    logic               defined;
    logic [SYM_W-1:0]   wsym;
    logic [MOVE_W-1:0]  mv;
    logic [STATE_W-1:0] nst;
  } rule_word_t;

  typedef struct packed {
    logic             written;
    logic [SYM_W-1:0] sym;
  } tape_word_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  localparam int RULE_WORD_W = $bits(rule_word_t);
  localparam int TAPE_WORD_W = $bits(tape_word_t);

endpackage

[rtl/tmse_ram.sv]
// simple dual port memory with registered read data
module tmse_ram
  import tmse_pkg::*;
#(
  parameter int DEPTH = TAPE_CELLS_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = TAPE_WORD_W
) (
  input  logic          clk,
  input  mem_ctl_t      ctl,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/tmse_seq.sv]
// command sequencer: clearing pass, step read-modify-write, result register
module tmse_seq
  import tmse_pkg::*;
#(
  parameter int STATE_COUNT = STATE_COUNT_DEF,
  parameter int TAPE_CELLS  = TAPE_CELLS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [CMD_W-1:0]        in_command,
  input  logic [STATE_W-1:0]      in_rule_state,
  input  logic [SYM_W-1:0]        in_symbol,
  input  logic [SYM_W-1:0]        in_write_symbol,
  input  logic [MOVE_W-1:0]       in_move,
  input  logic [STATE_W-1:0]      in_next_state,
  input  logic                    in_rule_valid,
  input  logic signed [POS_W-1:0] in_cell_position,
  input  logic [SYM_W-1:0]        blank_symbol,
  input  logic [STATE_W-1:0]      start_state,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [STAT_W-1:0]       out_status,
  output logic [STATE_W-1:0]      out_current_state,
  output logic signed [POS_W-1:0] out_head_position,
  output logic [SYM_W-1:0]        out_read_symbol,
  output mem_ctl_t                rule_ctl,
  output logic [$clog2(STATE_COUNT)+SYM_W-1:0] rule_rd_addr,
  output logic [$clog2(STATE_COUNT)+SYM_W-1:0] rule_wr_addr,
  output rule_word_t              rule_wr_data,
  input  rule_word_t              rule_rd_data,
  output mem_ctl_t                tape_ctl,
  output logic [$clog2(TAPE_CELLS)-1:0] tape_rd_addr,
  output logic [$clog2(TAPE_CELLS)-1:0] tape_wr_addr,
  output tape_word_t              tape_wr_data,
  input  tape_word_t              tape_rd_data
);

  localparam int SW         = $clog2(STATE_COUNT);
  localparam int RW         = SW + SYM_W;
  localparam int RULE_DEPTH = STATE_COUNT * 256;
  localparam int AW         = $clog2(TAPE_CELLS);
  localparam int HALF       = TAPE_CELLS / 2;
  localparam int RIGHT_EDGE = 2 * HALF - 1;
  localparam int CLEAR_LEN  = (RULE_DEPTH > TAPE_CELLS) ? RULE_DEPTH : TAPE_CELLS;
  localparam int CLW        = $clog2(CLEAR_LEN);
  localparam int PW         = (AW + 1 > POS_W) ? AW + 1 : POS_W;
  localparam int QW         = PW + 1;

  seq_state_t fsm_r, fsm_nxt;
  logic [CLW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [STATE_W-1:0] mstate_r, mstate_nxt;
  logic [SYM_W-1:0] rd_r, rd_nxt;

  cmd_t                    cmd_r;
  logic [STATE_W-1:0]      rstate_r;
  logic [SYM_W-1:0]        sym_r;
  logic [SYM_W-1:0]        wsym_r;
  logic [MOVE_W-1:0]       mv_r;
  logic [STATE_W-1:0]      nst_r;
  logic                    rvalid_r;
  logic signed [POS_W-1:0] pos_r;

  logic                    out_valid_r;
  logic [STAT_W-1:0]       out_status_r, out_status_nxt;
  logic [STATE_W-1:0]      out_state_r;
  logic signed [POS_W-1:0] out_head_r;
  logic [SYM_W-1:0]        out_rd_r, out_rd_nxt;
  logic                    out_load;
  logic                    out_free;

  logic [SYM_W-1:0]        rd_sym;
  logic signed [QW-1:0]    cell_idx;
  logic                    cell_in_win;
  logic [PW-1:0]           head_pos_w;

  // reduce a state index into the configured state range
  function automatic logic [STATE_W-1:0] state_mod(input logic [STATE_W-1:0] v);
    logic [8:0] acc;
    acc = {5'd0, v};
    for (int i = 0; i < 8; i++) begin
      if (acc >= 9'(STATE_COUNT)) acc = acc - 9'(STATE_COUNT);
    end
    return acc[STATE_W-1:0];
  endfunction

  assign out_free    = !out_valid_r || out_ready;
  assign rd_sym      = tape_rd_data.written ? tape_rd_data.sym : blank_symbol;
  assign cell_idx    = QW'(pos_r) + QW'(HALF);
  assign cell_in_win = !cell_idx[QW-1] && (cell_idx < QW'(TAPE_CELLS));
  assign head_pos_w  = PW'(head_nxt) - PW'(HALF);

  always_comb begin
    fsm_nxt        = fsm_r;
    clr_cnt_nxt    = clr_cnt_r;
    head_nxt       = head_r;
    mstate_nxt     = mstate_r;
    rd_nxt         = rd_r;
    in_ready       = 1'b0;
    out_load       = 1'b0;
    out_status_nxt = STAT_ACCEPTED;
    out_rd_nxt     = '0;
    rule_ctl       = '0;
    rule_rd_addr   = {SW'(mstate_r), rd_sym};
    rule_wr_addr   = {SW'(state_mod(rstate_r)), sym_r};
    rule_wr_data   = '0;
    tape_ctl       = '0;
    tape_rd_addr   = head_r;
    tape_wr_addr   = head_r;
    tape_wr_data   = '0;

    unique case (fsm_r)
      S_CLEAR: begin
        rule_ctl.wr_en = ({1'b0, clr_cnt_r} < (CLW+1)'(RULE_DEPTH));
        tape_ctl.wr_en = ({1'b0, clr_cnt_r} < (CLW+1)'(TAPE_CELLS));
        rule_wr_addr   = clr_cnt_r[RW-1:0];
        tape_wr_addr   = clr_cnt_r[AW-1:0];
        if (clr_cnt_r == CLW'(CLEAR_LEN - 1)) begin
          fsm_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end

      S_IDLE: begin
        in_ready       = 1'b1;
        tape_ctl.rd_en = 1'b1;
        if (in_valid) begin
          fsm_nxt = (cmd_t'(in_command) == CMD_STEP) ? S_RULE_RD : S_FINISH;
        end
      end

      S_RULE_RD: begin
        rd_nxt         = rd_sym;
        rule_ctl.rd_en = 1'b1;
        fsm_nxt        = S_COMMIT;
      end

      S_COMMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_rd_nxt = rd_r;
          fsm_nxt    = S_IDLE;
          if (!rule_rd_data.defined) begin
            out_status_nxt = STAT_HALTED;
          end else begin
            out_status_nxt       = STAT_STEPPED;
            tape_ctl.wr_en       = 1'b1;
            tape_wr_data.written = 1'b1;
            tape_wr_data.sym     = rule_rd_data.wsym;
            mstate_nxt           = rule_rd_data.nst;
            unique case (rule_rd_data.mv)
              MOVE_LEFT: begin
                if (head_r != '0) head_nxt = head_r - 1'b1;
                else out_status_nxt = STAT_EDGE_HELD;
              end
              MOVE_RIGHT: begin
                if (head_r != AW'(RIGHT_EDGE)) head_nxt = head_r + 1'b1;
                else out_status_nxt = STAT_EDGE_HELD;
              end
              default: begin
              end
            endcase
          end
        end
      end

      S_FINISH: begin
        if (out_free) begin
          out_load = 1'b1;
          fsm_nxt  = S_IDLE;
          unique case (cmd_r)
            CMD_WRITE_RULE: begin
              rule_ctl.wr_en       = 1'b1;
              rule_wr_data.defined = rvalid_r;
              rule_wr_data.wsym    = wsym_r;
              rule_wr_data.mv      = mv_r;
              rule_wr_data.nst     = state_mod(nst_r);
            end
            CMD_WRITE_CELL: begin
              tape_ctl.wr_en       = cell_in_win;
              tape_wr_addr         = cell_idx[AW-1:0];
              tape_wr_data.written = 1'b1;
              tape_wr_data.sym     = sym_r;
            end
            CMD_RESTART: begin
              mstate_nxt = state_mod(start_state);
              head_nxt   = AW'(HALF);
            end
            CMD_STEP: begin
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= S_CLEAR;
      clr_cnt_r   <= '0;
      head_r      <= AW'(HALF);
      mstate_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fsm_r       <= fsm_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      head_r      <= head_nxt;
      mstate_r    <= mstate_nxt;
      out_valid_r <= out_load || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= rd_nxt;
    if (in_valid && in_ready) begin
      cmd_r    <= cmd_t'(in_command);
      rstate_r <= in_rule_state;
      sym_r    <= in_symbol;
      wsym_r   <= in_write_symbol;
      mv_r     <= in_move;
      nst_r    <= in_next_state;
      rvalid_r <= in_rule_valid;
      pos_r    <= in_cell_position;
    end
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_state_r  <= mstate_nxt;
      out_head_r   <= head_pos_w[POS_W-1:0];
      out_rd_r     <= out_rd_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_current_state = out_state_r;
  assign out_head_position = out_head_r;
  assign out_read_symbol   = out_rd_r;

endmodule

[rtl/turing_machine_step_engine.sv]
// top level of the turing machine step engine
// Single-tape Turing machine engine built around two memories: a rule store
// of STATE_COUNT*256 words keyed by {state, symbol} and a tape store of
// TAPE_CELLS words, each word carrying its own defined/written mark. Right
// after reset the engine sweeps both memories once to clear those marks,
// one address per cycle over max(STATE_COUNT*256, TAPE_CELLS) addresses (4096
// with the default sizes); in_ready stays low for the sweep while configuration
// writes are taken as usual. Afterwards one request is in flight at a time.
// Rule writes, tape writes and restarts go from the accept in S_IDLE to
// S_FINISH, where the result is loaded; a step goes through S_IDLE, S_RULE_RD
// and S_COMMIT: the tape cell under the head is read in the accept cycle, the
// rule for {state, symbol read} in the next, and the write-back of cell, head
// and state happens with the result load in S_COMMIT. That chain of two
// dependent synchronous reads sets the step time.
// Since the next request is only taken once the write-back is done, no two
// accesses to one memory entry ever overlap. A result waiting on out_ready
// does not stop the next request from being accepted; it only holds the
// final cycle of that next request until the result register is free.
// Head positions run from -TAPE_CELLS/2 to TAPE_CELLS/2-1; a move past an
// edge leaves the head in place and reports status 3.
`include "turing_machine_step_engine_assert.svh"

module turing_machine_step_engine
  import tmse_pkg::*;
#(
  parameter int STATE_COUNT = STATE_COUNT_DEF,
  parameter int TAPE_CELLS  = TAPE_CELLS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // request channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [CMD_W-1:0]        in_command,
  input  logic [STATE_W-1:0]      in_rule_state,
  input  logic [SYM_W-1:0]        in_symbol,
  input  logic [SYM_W-1:0]        in_write_symbol,
  input  logic [MOVE_W-1:0]       in_move,
  input  logic [STATE_W-1:0]      in_next_state,
  input  logic                    in_rule_valid,
  input  logic signed [POS_W-1:0] in_cell_position,
  // result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [STAT_W-1:0]       out_status,
  output logic [STATE_W-1:0]      out_current_state,
  output logic signed [POS_W-1:0] out_head_position,
  output logic [SYM_W-1:0]        out_read_symbol,
  // configuration writes
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int SW         = $clog2(STATE_COUNT);
  localparam int RW         = SW + SYM_W;
  localparam int RULE_DEPTH = STATE_COUNT * 256;
  localparam int AW         = $clog2(TAPE_CELLS);

  // configuration registers
  logic [SYM_W-1:0]   blank_r;
  logic [STATE_W-1:0] start_r;

  // memory request lines between sequencer and stores
  mem_ctl_t   rule_ctl;
  logic [RW-1:0] rule_rd_addr;
  logic [RW-1:0] rule_wr_addr;
  rule_word_t rule_wr_data;
  rule_word_t rule_rd_data;
  mem_ctl_t   tape_ctl;
  logic [AW-1:0] tape_rd_addr;
  logic [AW-1:0] tape_wr_addr;
  tape_word_t tape_wr_data;
  tape_word_t tape_rd_data;

  // the user writes registers only while the engine is idle; the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blank_r <= BLANK_RESET;
      start_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLANK_SYMBOL: blank_r <= cfg_wdata;
        CFG_START_STATE:  start_r <= cfg_wdata[STATE_W-1:0];
      endcase
    end
  end

  // sequencer: clear sweep, command decode, head/state registers, result register
  tmse_seq #(
    .STATE_COUNT (STATE_COUNT),
    .TAPE_CELLS  (TAPE_CELLS)
  ) u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_rule_state     (in_rule_state),
    .in_symbol         (in_symbol),
    .in_write_symbol   (in_write_symbol),
    .in_move           (in_move),
    .in_next_state     (in_next_state),
    .in_rule_valid     (in_rule_valid),
    .in_cell_position  (in_cell_position),
    .blank_symbol      (blank_r),
    .start_state       (start_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_current_state (out_current_state),
    .out_head_position (out_head_position),
    .out_read_symbol   (out_read_symbol),
    .rule_ctl          (rule_ctl),
    .rule_rd_addr      (rule_rd_addr),
    .rule_wr_addr      (rule_wr_addr),
    .rule_wr_data      (rule_wr_data),
    .rule_rd_data      (rule_rd_data),
    .tape_ctl          (tape_ctl),
    .tape_rd_addr      (tape_rd_addr),
    .tape_wr_addr      (tape_wr_addr),
    .tape_wr_data      (tape_wr_data),
    .tape_rd_data      (tape_rd_data)
  );

  // rule store: defined mark, write symbol, move, next state
  tmse_ram #(
    .DEPTH (RULE_DEPTH),
    .AW    (RW),
    .DW    (RULE_WORD_W)
  ) u_rule_ram (
    .clk     (clk),
    .ctl     (rule_ctl),
    .wr_addr (rule_wr_addr),
    .wr_data (rule_wr_data),
    .rd_addr (rule_rd_addr),
    .rd_data (rule_rd_data)
  );

  // tape store: written mark and symbol per cell
  tmse_ram #(
    .DEPTH (TAPE_CELLS),
    .AW    (AW),
    .DW    (TAPE_WORD_W)
  ) u_tape_ram (
    .clk     (clk),
    .ctl     (tape_ctl),
    .wr_addr (tape_wr_addr),
    .wr_data (tape_wr_data),
    .rd_addr (tape_rd_addr),
    .rd_data (tape_rd_data)
  );

  // reads and writes of one store never share a cycle, so no forwarding is needed
  `TMSE_ASSERT_NEVER(a_rule_no_overlap, clk, rst_n, rule_ctl.rd_en && rule_ctl.wr_en,
    "rule store read and write in the same cycle")
  `TMSE_ASSERT_NEVER(a_tape_no_overlap, clk, rst_n, tape_ctl.rd_en && tape_ctl.wr_en,
    "tape store read and write in the same cycle")
  // one request in flight: acceptance closes the request channel
  `TMSE_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready,
    "request accepted while another is in flight")

endmodule

[verif/tm_result_compare.sv]
// result predictor and comparator for the turing machine step engine
module tm_result_compare
  import tmse_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [CMD_W-1:0]        in_command,
  input  logic [STATE_W-1:0]      in_rule_state,
  input  logic [SYM_W-1:0]        in_symbol,
  input  logic [SYM_W-1:0]        in_write_symbol,
  input  logic [MOVE_W-1:0]       in_move,
  input  logic [STATE_W-1:0]      in_next_state,
  input  logic                    in_rule_valid,
  input  logic signed [POS_W-1:0] in_cell_position,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [STAT_W-1:0]       out_status,
  input  logic [STATE_W-1:0]      out_current_state,
  input  logic signed [POS_W-1:0] out_head_position,
  input  logic [SYM_W-1:0]        out_read_symbol,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  output int                      pending,
  output int                      error_count,
  output int                      halt_count,
  output int                      edge_count
);

  localparam int HALF_TAPE  = TAPE_CELLS_DEF / 2;
  localparam int RULE_DEPTH = STATE_COUNT_DEF * 256;

  typedef struct packed {
    logic [SYM_W-1:0]   wsym;
    logic [MOVE_W-1:0]  mv;
    logic [STATE_W-1:0] nst;
  } rule_t;

  typedef struct {
    status_t                 status;
    logic [STATE_W-1:0]      st;
    logic signed [POS_W-1:0] head;
    logic [SYM_W-1:0]        rd;
  } machine_result_t;

  rule_t                   rule_mem [RULE_DEPTH];
  bit                      rule_set [RULE_DEPTH];
  logic [SYM_W-1:0]        tape_mem [TAPE_CELLS_DEF];
  bit                      tape_set [TAPE_CELLS_DEF];
  logic signed [POS_W-1:0] head_q;
  logic [STATE_W-1:0]      state_q;
  logic [SYM_W-1:0]        blank_q;
  logic [STATE_W-1:0]      start_q;
  machine_result_t         machine_results_q [$];
  int                      errs;
  int                      halts;
  int                      edges;

  // applies one request to the machine copy and returns the result it gives
  function automatic machine_result_t run_command(
    input cmd_t                    c,
    input logic [STATE_W-1:0]      rs,
    input logic [SYM_W-1:0]        sym,
    input logic [SYM_W-1:0]        ws,
    input logic [MOVE_W-1:0]       mv,
    input logic [STATE_W-1:0]      ns,
    input logic                    rv,
    input logic signed [POS_W-1:0] pos
  );
    machine_result_t r;
    int              key;
    int              tidx;
    rule_t           w;
    r.status = STAT_ACCEPTED;
    r.rd     = '0;
    case (c)
      CMD_WRITE_RULE: begin
        key           = int'({rs, sym});
        rule_mem[key] = '{wsym: ws, mv: mv, nst: ns};
        rule_set[key] = rv;
      end
      CMD_WRITE_CELL: begin
        tidx = int'(pos) + HALF_TAPE;
        if (tidx >= 0 && tidx < TAPE_CELLS_DEF) begin
          tape_mem[tidx] = sym;
          tape_set[tidx] = 1'b1;
        end
      end
      CMD_RESTART: begin
        state_q = start_q;
        head_q  = '0;
      end
      default: begin
        tidx = int'(head_q) + HALF_TAPE;
        r.rd = tape_set[tidx] ? tape_mem[tidx] : blank_q;
        key  = int'({state_q, r.rd});
        if (!rule_set[key]) begin
          r.status = STAT_HALTED;
          halts++;
        end else begin
          w              = rule_mem[key];
          tape_mem[tidx] = w.wsym;
          tape_set[tidx] = 1'b1;
          r.status       = STAT_STEPPED;
          if (w.mv == MOVE_LEFT) begin
            if (int'(head_q) > -HALF_TAPE) head_q = head_q - 10'sd1;
            else r.status = STAT_EDGE_HELD;
          end else if (w.mv == MOVE_RIGHT) begin
            if (int'(head_q) < HALF_TAPE - 1) head_q = head_q + 10'sd1;
            else r.status = STAT_EDGE_HELD;
          end
          if (r.status == STAT_EDGE_HELD) edges++;
          state_q = w.nst;
        end
      end
    endcase
    r.st   = state_q;
    r.head = head_q;
    return r;
  endfunction

  always @(posedge clk) begin
    machine_result_t want;
    if (!rst_n) begin
      foreach (rule_set[i]) rule_set[i] = 1'b0;
      foreach (tape_set[i]) tape_set[i] = 1'b0;
      head_q  = '0;
      state_q = '0;
      blank_q = BLANK_RESET;
      start_q = '0;
      machine_results_q.delete();
      errs  = 0;
      halts = 0;
      edges = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (machine_results_q.size() == 0) begin
          $error("result with no request pending: status %0d state %0d head %0d read %0d",
                 out_status, out_current_state, out_head_position, out_read_symbol);
          errs++;
        end else begin
          want = machine_results_q.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            errs++;
          end
          if (out_current_state !== want.st) begin
            $error("current_state: expected %0d, got %0d", want.st, out_current_state);
            errs++;
          end
          if (out_head_position !== want.head) begin
            $error("head_position: expected %0d, got %0d", want.head, out_head_position);
            errs++;
          end
          if (out_read_symbol !== want.rd) begin
            $error("read_symbol: expected %0d, got %0d", want.rd, out_read_symbol);
            errs++;
          end
        end
      end
      if (in_valid && in_ready)
        machine_results_q.insert(machine_results_q.size(),
                                 run_command(cmd_t'(in_command), in_rule_state, in_symbol,
                                             in_write_symbol, in_move, in_next_state,
                                             in_rule_valid, in_cell_position));
      if (cfg_we) begin
        if (cfg_index == CFG_BLANK_SYMBOL) blank_q = cfg_wdata;
        else if (cfg_index == CFG_START_STATE) start_q = cfg_wdata[STATE_W-1:0];
      end
    end
    pending     <= machine_results_q.size();
    error_count <= errs;
    halt_count  <= halts;
    edge_count  <= edges;
  end

endmodule

[verif/tb_turing_machine_step_engine.sv]
// testbench top for the turing machine step engine: stimulus, idling and verdict
module tb_turing_machine_step_engine;
  import tmse_pkg::*;

  // move codes the package leaves unnamed
  localparam logic [MOVE_W-1:0] MOVE_STAY = 2'd0;
  localparam logic [MOVE_W-1:0] MOVE_ODD  = 2'd3;

  // rough number of random requests after the directed part and the edge sweep
  localparam int RANDOM_REQUESTS = 200;

  logic                    clk   = 1'b0;
  logic                    rst_n = 1'b0;

  logic                    in_valid         = 1'b0;
  logic                    in_ready;
  logic [CMD_W-1:0]        in_command       = '0;
  logic [STATE_W-1:0]      in_rule_state    = '0;
  logic [SYM_W-1:0]        in_symbol        = '0;
  logic [SYM_W-1:0]        in_write_symbol  = '0;
  logic [MOVE_W-1:0]       in_move          = '0;
  logic [STATE_W-1:0]      in_next_state    = '0;
  logic                    in_rule_valid    = 1'b0;
  logic signed [POS_W-1:0] in_cell_position = '0;

  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [STAT_W-1:0]       out_status;
  logic [STATE_W-1:0]      out_current_state;
  logic signed [POS_W-1:0] out_head_position;
  logic [SYM_W-1:0]        out_read_symbol;

  logic                    cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

  int pending;
  int error_count;
  int halt_count;
  int edge_count;

  // both sides run without idling while this is set
  bit burst_mode = 1'b0;
  // each increment asks the result side for one long hold-off
  int hold_asks  = 0;

  // stimulus-side bookkeeping: request counts per command, symbols that can
  // sit on the tape, and the register values last written
  int         cmd_count [4];
  int         sent_total = 0;
  bit [255:0] used_sym   = '0;
  logic [7:0] blank_now  = BLANK_RESET;
  logic [3:0] start_now  = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  turing_machine_step_engine i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_rule_state    (in_rule_state),
    .in_symbol        (in_symbol),
    .in_write_symbol  (in_write_symbol),
    .in_move          (in_move),
    .in_next_state    (in_next_state),
    .in_rule_valid    (in_rule_valid),
    .in_cell_position (in_cell_position),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_current_state(out_current_state),
    .out_head_position(out_head_position),
    .out_read_symbol  (out_read_symbol),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  tm_result_compare u_compare (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_rule_state    (in_rule_state),
    .in_symbol        (in_symbol),
    .in_write_symbol  (in_write_symbol),
    .in_move          (in_move),
    .in_next_state    (in_next_state),
    .in_rule_valid    (in_rule_valid),
    .in_cell_position (in_cell_position),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_current_state(out_current_state),
    .out_head_position(out_head_position),
    .out_read_symbol  (out_read_symbol),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .pending          (pending),
    .error_count      (error_count),
    .halt_count       (halt_count),
    .edge_count       (edge_count)
  );

  // idle length: mostly none, sometimes a short gap, rarely a long gap
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offers one request and returns at the edge where it is accepted; valid
  // stays high afterwards so a back-to-back request never drops it
  task automatic send(input cmd_t                    c,
                      input logic [STATE_W-1:0]      rs,
                      input logic [SYM_W-1:0]        sym,
                      input logic [SYM_W-1:0]        ws,
                      input logic [MOVE_W-1:0]       mv,
                      input logic [STATE_W-1:0]      ns,
                      input logic                    rv,
                      input logic signed [POS_W-1:0] pos);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_command       <= c;
    in_rule_state    <= rs;
    in_symbol        <= sym;
    in_write_symbol  <= ws;
    in_move          <= mv;
    in_next_state    <= ns;
    in_rule_valid    <= rv;
    in_cell_position <= pos;
    do @(posedge clk); while (!in_ready);
    cmd_count[int'(c)]++;
    sent_total++;
    if (c == CMD_WRITE_CELL) used_sym[sym] = 1'b1;
    if (c == CMD_WRITE_RULE) used_sym[ws] = 1'b1;
  endtask

  // rule write; the tape position field is don't-care and gets noise
  task automatic put_rule(input logic [3:0] st, input logic [7:0] sym, input logic [7:0] ws,
                          input logic [1:0] mv, input logic [3:0] ns, input logic rv);
    send(CMD_WRITE_RULE, st, sym, ws, mv, ns, rv, 10'($urandom));
  endtask

  // tape cell write; rule fields are don't-care
  task automatic put_cell(input logic signed [9:0] pos, input logic [7:0] sym);
    send(CMD_WRITE_CELL, 4'($urandom), sym, 8'($urandom), 2'($urandom), 4'($urandom),
         1'($urandom), pos);
  endtask

  // restart or step with all payload fields random
  task automatic machine_cmd(input cmd_t c);
    send(c, 4'($urandom), 8'($urandom), 8'($urandom), 2'($urandom), 4'($urandom),
         1'($urandom), 10'($urandom));
  endtask

  // stop offering and wait until every predicted result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    // let the write-back of the last request settle
    repeat (6) @(posedge clk);
  endtask

  // register write; only called once the engine has drained
  task automatic set_config(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_BLANK_SYMBOL) blank_now = val;
    else start_now = val[3:0];
  endtask

  // loads a rule for every symbol that can be on the tape so that the head
  // keeps walking in one direction, then walks it into the edge
  task automatic sweep(input logic [3:0] st, input logic [1:0] dir, input int steps);
    for (int s = 0; s < 256; s++)
      if (used_sym[s] || s == int'(blank_now)) put_rule(st, 8'(s), 8'(s), dir, st, 1'b1);
    machine_cmd(CMD_RESTART);
    repeat (steps) machine_cmd(CMD_STEP);
  endtask

  // result side: random stalls, plus long hold-offs on request
  initial begin : result_side
    int gap;
    int hold;
    int served;
    gap    = 0;
    hold   = 0;
    served = 0;
    forever begin
      @(posedge clk);
      if (served != hold_asks) begin
        served = hold_asks;
        hold   = $urandom_range(150, 250);
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        gap = pick_gap();
      end
    end
  end

  initial begin : stimulus
    logic [7:0] alpha [4];
    logic [3:0] sts [4];
    logic [3:0] walk_st;
    logic [7:0] cfg_val;
    int         na;
    int         nstates;
    int         base;
    int         pick;
    int         hold_pick;

    foreach (cmd_count[i]) cmd_count[i] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed part; blank is '.' and start state 0 out of reset
    put_rule(4'd1, 8'h2E, 8'h52, MOVE_STAY, 4'd15, 1'b0);   // remove a rule never set
    put_cell(-10'sd512, 8'hFF);                              // left end of the window
    put_cell(10'sd511, 8'h00);                               // right end of the window
    put_cell(-10'sd2, 8'h52);
    machine_cmd(CMD_RESTART);
    put_rule(4'd0, 8'h2E, 8'h4C, MOVE_RIGHT, 4'd1, 1'b1);
    machine_cmd(CMD_STEP);                                   // blank read, moves right
    machine_cmd(CMD_STEP);                                   // no rule: halt
    put_rule(4'd1, 8'h2E, 8'hFF, MOVE_STAY, 4'd15, 1'b1);
    machine_cmd(CMD_STEP);                                   // write in place
    put_rule(4'd15, 8'hFF, 8'hFF, MOVE_ODD, 4'd15, 1'b1);
    machine_cmd(CMD_STEP);                                   // move code three stays put
    put_rule(4'd15, 8'hFF, 8'h00, MOVE_LEFT, 4'd0, 1'b1);
    machine_cmd(CMD_STEP);
    machine_cmd(CMD_STEP);
    drain();
    set_config(CFG_BLANK_SYMBOL, 8'hFF);
    set_config(CFG_START_STATE, 8'h0F);
    machine_cmd(CMD_RESTART);                                // restart keeps tape and rules
    put_rule(4'd15, 8'h4C, 8'h4C, MOVE_LEFT, 4'd15, 1'b1);
    machine_cmd(CMD_STEP);
    machine_cmd(CMD_STEP);                                   // unwritten cell reads new blank
    machine_cmd(CMD_STEP);
    drain();
    set_config(CFG_BLANK_SYMBOL, 8'h00);
    machine_cmd(CMD_STEP);

    // edge sweep: walk to the left edge and push past it a few times, while
    // the result side holds off and requests keep coming, so the engine backs up
    drain();
    walk_st      = 4'($urandom_range(0, 15));
    cfg_val      = 8'($urandom);
    cfg_val[3:0] = walk_st;
    set_config(CFG_START_STATE, cfg_val);
    burst_mode <= 1'b1;
    hold_asks  <= hold_asks + 1;
    sweep(walk_st, MOVE_LEFT, 516);

    // random part: mostly small programs run for a while, some noise
    base = sent_total;
    while (sent_total - base < RANDOM_REQUESTS) begin
      pick      = $urandom_range(0, 9);
      hold_pick = $urandom_range(0, 1);
      // a long hold-off always runs with the sender at full speed
      burst_mode <= (pick == 9 && hold_pick == 1) || ($urandom_range(0, 99) < 15);
      case (pick)
        7, 8: begin
          // unstructured requests, every field random
          repeat ($urandom_range(5, 20))
            send(cmd_t'($urandom_range(0, 3)), 4'($urandom), 8'($urandom), 8'($urandom),
                 2'($urandom), 4'($urandom), 1'($urandom), 10'($urandom));
        end
        9: begin
          if (hold_pick == 0) begin
            // sender pauses until everything is back
            drain();
          end else begin
            hold_asks <= hold_asks + 1;
            repeat (20) machine_cmd(CMD_STEP);
          end
        end
        default: begin
          // occasionally change the registers between programs, extremes often
          if ($urandom_range(0, 3) == 0) begin
            drain();
            case ($urandom_range(0, 3))
              0:       cfg_val = 8'h00;
              1:       cfg_val = 8'hFF;
              default: cfg_val = 8'($urandom);
            endcase
            set_config(CFG_BLANK_SYMBOL, cfg_val);
            cfg_val = 8'($urandom);
            case ($urandom_range(0, 3))
              0:       cfg_val[3:0] = 4'd0;
              1:       cfg_val[3:0] = 4'd15;
              default: ;
            endcase
            set_config(CFG_START_STATE, cfg_val);
          end
          // small alphabet around the blank and a few states from the start
          // state, so rules actually match and the machine keeps running
          na       = $urandom_range(2, 4);
          nstates  = $urandom_range(1, 4);
          alpha[0] = blank_now;
          sts[0]   = start_now;
          for (int j = 1; j < 4; j++) begin
            alpha[j] = 8'($urandom);
            sts[j]   = 4'($urandom);
          end
          for (int i = 0; i < nstates; i++)
            for (int j = 0; j < na; j++)
              if ($urandom_range(0, 9) < 8)
                put_rule(sts[i], alpha[j], alpha[$urandom_range(0, na - 1)],
                         2'($urandom_range(0, 3)), sts[$urandom_range(0, nstates - 1)],
                         $urandom_range(0, 9) != 0);
          repeat ($urandom_range(0, 6))
            put_cell(10'(int'($urandom_range(0, 16)) - 8), alpha[$urandom_range(0, na - 1)]);
          machine_cmd(CMD_RESTART);
          repeat ($urandom_range(8, 40)) begin
            if ($urandom_range(0, 29) == 0) machine_cmd(CMD_RESTART);
            machine_cmd(CMD_STEP);
          end
        end
      endcase
    end
    burst_mode <= 1'b0;

    // all requests taken: wait for the last results, then give the verdict
    drain();
    $display("summary: %0d requests: %0d rule writes, %0d cell writes, %0d restarts, %0d steps",
             sent_total, cmd_count[int'(CMD_WRITE_RULE)], cmd_count[int'(CMD_WRITE_CELL)],
             cmd_count[int'(CMD_RESTART)], cmd_count[int'(CMD_STEP)]);
    $display("summary: %0d halts on a missing rule, %0d steps held at a tape edge",
             halt_count, edge_count);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run, clearing sweep included
  initial begin : watchdog
    #6000000;
    $display("status: fail");
    $finish;
  end

endmodule
